// File: hw/rtl/rdnp_pkg.sv
// Shared types and constants for the radix-detecting number parser.
// No dependencies; every other file of the block uses it.
package rdnp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_WIDTH       = 32;

    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_HEX = 2'd1;
    localparam logic [1:0] KIND_OCT = 2'd2;
    localparam logic [1:0] KIND_BIN = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_symbol;
    } sym_item_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic [1:0]           radix_kind;
    } res_item_t;

    // Pre-decoded character as it travels through the queue
    typedef struct packed {
        logic [3:0] dec_digit;
        logic [2:0] oct_digit;
        logic [3:0] hex_digit;
        logic       is_zero;
        logic       is_x;
        logic       is_b;
        logic       last;
    } sym_class_t;

endpackage

// File: hw/rtl/rdnp_front.sv
// Front end: takes character transfers and decodes them into digit classes.
// Depends on rdnp_pkg.
module rdnp_front
(
    input  logic                  sym_valid,
    output logic                  sym_ready,
    input  rdnp_pkg::sym_item_t   sym,
    input  logic                  queue_full,
    output logic                  push,
    output rdnp_pkg::sym_class_t  push_data
);

    logic [7:0] c;

    assign c         = sym.symbol;
    assign sym_ready = !queue_full;
    assign push      = sym_valid && !queue_full;

    always_comb
    begin
        push_data = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            push_data.dec_digit = c[3:0];
            push_data.hex_digit = c[3:0];
        end
        if (c >= 8'h30 && c <= 8'h37)
            push_data.oct_digit = c[2:0];
        // 'A'..'F' and 'a'..'f' share the low three bits: 1..6 maps to 10..15
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            push_data.hex_digit = 4'(c[2:0]) + 4'd9;
        push_data.is_zero = (c == 8'h30);
        push_data.is_x    = (c == 8'h78) || (c == 8'h58);
        push_data.is_b    = (c == 8'h62);
        push_data.last    = sym.final_symbol;
    end

endmodule

// File: hw/rtl/rdnp_queue.sv
// Short queue between the decode front end and the accumulating back end.
// Depends on rdnp_pkg.
module rdnp_queue
#(
    parameter int DEPTH = rdnp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rdnp_pkg::sym_class_t  push_data,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output rdnp_pkg::sym_class_t  head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rdnp_pkg::sym_class_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hw/rtl/rdnp_back.sv
// Back end: runs the hex/octal/decimal and binary accumulations and holds the result.
// Depends on rdnp_pkg.
module rdnp_back
#(
    parameter int VALUE_WIDTH = rdnp_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  rdnp_pkg::sym_class_t  head,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output rdnp_pkg::res_item_t   res
);

    localparam int OW = rdnp_pkg::OUT_WIDTH;

    logic [1:0]             pos_reg, pos_next;
    logic                   lz_reg, lz_next;
    logic                   hex_reg, hex_next;
    logic [VALUE_WIDTH-1:0] racc_reg, racc_next;
    logic [VALUE_WIDTH-1:0] bacc_reg, bacc_next;
    logic                   res_valid_reg, res_valid_next;
    rdnp_pkg::res_item_t    res_reg, res_next;

    logic [VALUE_WIDTH-1:0] racc_step;
    logic [VALUE_WIDTH-1:0] result_value;
    logic [VALUE_WIDTH+OW-1:0] result_ext;
    logic [1:0]             kind;

    // A final character needs room in the output register; others never wait
    assign pop       = head_valid && (!head.last || !res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        lz_next   = lz_reg;
        hex_next  = hex_reg;
        racc_step = racc_reg;
        if (pos_reg == 2'd0)
        begin
            lz_next   = head.is_zero;
            hex_next  = 1'b0;
            racc_step = VALUE_WIDTH'(head.dec_digit);
        end
        else if (pos_reg == 2'd1 && lz_reg && head.is_x)
        begin
            hex_next  = 1'b1;
            racc_step = '0;
        end
        else if (hex_reg)
            racc_step = (racc_reg << 4) + VALUE_WIDTH'(head.hex_digit);
        else if (lz_reg)
            racc_step = (racc_reg << 3) + VALUE_WIDTH'(head.oct_digit);
        else
            racc_step = (racc_reg << 3) + (racc_reg << 1) + VALUE_WIDTH'(head.dec_digit);
    end

    always_comb
    begin
        if (hex_next)
        begin
            kind         = rdnp_pkg::KIND_HEX;
            result_value = racc_step;
        end
        else if (pos_reg != 2'd0 && head.is_b)
        begin
            kind         = rdnp_pkg::KIND_BIN;
            result_value = bacc_reg;
        end
        else if (lz_next)
        begin
            kind         = rdnp_pkg::KIND_OCT;
            result_value = racc_step;
        end
        else
        begin
            kind         = rdnp_pkg::KIND_DEC;
            result_value = racc_step;
        end
        result_ext = {{OW{1'b0}}, result_value};
    end

    always_comb
    begin
        pos_next       = pos_reg;
        racc_next      = racc_reg;
        bacc_next      = bacc_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;
        if (pop)
        begin
            if (head.last)
            begin
                pos_next            = 2'd0;
                racc_next           = '0;
                bacc_next           = '0;
                res_valid_next      = 1'b1;
                res_next.value      = result_ext[OW-1:0];
                res_next.radix_kind = kind;
            end
            else
            begin
                pos_next  = (pos_reg == 2'd2) ? 2'd2 : pos_reg + 2'd1;
                racc_next = racc_step;
                bacc_next = {bacc_reg[VALUE_WIDTH-2:0], !head.is_zero};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            lz_reg        <= 1'b0;
            hex_reg       <= 1'b0;
            racc_reg      <= '0;
            bacc_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            racc_reg      <= racc_next;
            bacc_reg      <= bacc_next;
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                lz_reg  <= head.last ? 1'b0 : lz_next;
                hex_reg <= head.last ? 1'b0 : hex_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

`ifndef SYNTH
    a_new_string_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.last |=> pos_reg == 2'd0 && !hex_reg && !lz_reg)
        else $error("string state not cleared after final character");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("position count beyond saturation");

    a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(pop && head.last))
        else $error("result raised without a final character");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |-> !(pop && head.last))
        else $error("pending result overwritten");
`endif

endmodule

// File: hw/rtl/radix_detecting_number_parser_core.sv
// Radix-detecting number parser: one character per transfer, result on the final one.
// Result path: the final character's transfer is written into the queue, then accumulated
// into the output register, from which the result transfer is offered; decode is combinational.
// Throughput: one character per cycle, except while a final character waits for the sink to take the pending result.
// The QUEUE_DEPTH-entry queue (4 by default) lets decode keep taking characters while a result waits for the sink.
// Reset: rst_n asynchronous, active low; empties the queue, clears string state and result valid.
module radix_detecting_number_parser_core
#(
    parameter int VALUE_WIDTH = rdnp_pkg::VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = rdnp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sym_valid,
    output logic                 sym_ready,
    input  rdnp_pkg::sym_item_t  sym,
    output logic                 res_valid,
    input  logic                 res_ready,
    output rdnp_pkg::res_item_t  res
);

    logic                  push;
    rdnp_pkg::sym_class_t  push_data;
    logic                  queue_full;
    logic                  head_valid;
    rdnp_pkg::sym_class_t  head;
    logic                  pop;

    rdnp_front u_front
    (
        .sym_valid  (sym_valid),
        .sym_ready  (sym_ready),
        .sym        (sym),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    rdnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (head_valid),
        .head      (head)
    );

    rdnp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule
